@@ rtl/sparse_matrix_csr_store_core_assert.svh @@
`ifndef SPARSE_MATRIX_CSR_STORE_CORE_ASSERT_SVH
`define SPARSE_MATRIX_CSR_STORE_CORE_ASSERT_SVH

// Assertion helpers. They expect signals named clock and reset in the using module.

// The condition holds at every edge outside reset.
`define SMCS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define SMCS_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define SMCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/smcs_pkg.sv @@
package smcs_pkg;

   localparam int VALUE_WIDTH      = 32;
   localparam int CFG_WIDTH        = 7;
   localparam int POS_WIDTH        = 6;
   localparam int NZ_COUNT_WIDTH   = 13;

   localparam int DEF_MAX_ROWS     = 64;
   localparam int DEF_MAX_COLS     = 64;
   localparam int DEF_MAX_NONZEROS = 4096;

   localparam int CSR_INDEX_WIDTH  = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_COLS = 1'b1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_RANGE      = 2'd1,
      STATUS_NOT_LOADED = 2'd2,
      STATUS_OVERFLOW   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_QUERY,
      OP_QUERY_RANGE
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]          row;
      logic [POS_WIDTH-1:0]          col;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } fe_item_type;

endpackage

@@ rtl/smcs_ram.sv @@
module smcs_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/smcs_front.sv @@
module smcs_front
   import smcs_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic [CFG_WIDTH-1:0]          rows_eff,
   input  logic [CFG_WIDTH-1:0]          cols_eff,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_element_value,
   input  logic [POS_WIDTH-1:0]          req_query_row,
   input  logic [POS_WIDTH-1:0]          req_query_col,
   output fe_item_type                   fe,
   input  logic                          pop
);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push;
   item_type              new_item;

   // Range uses current dimensions; user must change them only while idle (unenforced).
   always_comb begin
      new_item.value = req_element_value;
      new_item.row   = req_query_row;
      new_item.col   = req_query_col;
      if (req_kind == KIND_LOAD) begin
         new_item.op = OP_LOAD;
      end else if ({1'b0, req_query_row} >= rows_eff || {1'b0, req_query_col} >= cols_eff) begin
         new_item.op = OP_QUERY_RANGE;
      end else begin
         new_item.op = OP_QUERY;
      end
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign fe.valid = (count_ff != '0);
   assign fe.item  = entry_ff[rd_ptr_ff];

endmodule

@@ rtl/smcs_back.sv @@
`include "sparse_matrix_csr_store_core_assert.svh"

module smcs_back
   import smcs_pkg::*;
#(
   parameter int MAX_ROWS     = DEF_MAX_ROWS,
   parameter int MAX_COLS     = DEF_MAX_COLS,
   parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [CFG_WIDTH-1:0]          rows_eff,
   input  logic [CFG_WIDTH-1:0]          cols_eff,
   input  fe_item_type                   fe,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_value,
   output status_type                    rsp_status,
   output logic [NZ_COUNT_WIDTH-1:0]     rsp_count
);

   localparam int COL_LIMIT = (MAX_COLS < 127) ? MAX_COLS : 127;
   localparam int COL_W     = (COL_LIMIT > 1) ? $clog2(COL_LIMIT) : 1;
   localparam int CNT_W     = $clog2(MAX_NONZEROS + 1);
   localparam int ADDR_W    = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
   localparam int RS_DEPTH  = MAX_ROWS + 1;
   localparam int RS_AW     = $clog2(RS_DEPTH);
   localparam int DATA_W    = VALUE_WIDTH + COL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FINISH,
      ST_ROW_LO,
      ST_ROW_HI,
      ST_SCAN
   } state_type;

   state_type                     state_ff, state_in;
   logic [CFG_WIDTH-1:0]          load_row_ff, load_row_in;
   logic [COL_W-1:0]              load_col_ff, load_col_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          loaded_ff, loaded_in;
   logic [CNT_W-1:0]              ptr_ff, ptr_in;
   logic [CNT_W-1:0]              end_ff, end_in;
   logic [POS_WIDTH-1:0]          qcol_ff, qcol_in;
   logic [RS_AW-1:0]              row_next_ff, row_next_in;
   status_type                    status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic [NZ_COUNT_WIDTH-1:0]     rsp_count_ff, rsp_count_in;

   logic                          res_load;
   logic signed [VALUE_WIDTH-1:0] res_value;
   status_type                    res_status;
   status_type                    ld_status;
   logic                          out_free;
   logic                          load_blocked;
   logic [CFG_WIDTH-1:0]          col_inc;
   logic [CFG_WIDTH-1:0]          row_inc;
   logic                          col_last;
   logic [CNT_W-1:0]              ptr_next;

   logic                          rs_wr_en, rs_rd_en;
   logic [RS_AW-1:0]              rs_wr_addr, rs_rd_addr;
   logic [CNT_W-1:0]              rs_wr_data, rs_rd_data;
   logic                          dt_wr_en, dt_rd_en;
   logic [ADDR_W-1:0]             dt_wr_addr, dt_rd_addr;
   logic [DATA_W-1:0]             dt_wr_data, dt_rd_data;
   logic signed [VALUE_WIDTH-1:0] dt_rd_value;
   logic [COL_W-1:0]              dt_rd_col;

   smcs_ram #(.WIDTH(CNT_W), .DEPTH(RS_DEPTH)) u_row_start_ram (
      .clock   (clock),
      .wr_en   (rs_wr_en),
      .wr_addr (rs_wr_addr),
      .wr_data (rs_wr_data),
      .rd_en   (rs_rd_en),
      .rd_addr (rs_rd_addr),
      .rd_data (rs_rd_data)
   );

   // Value and column of one stored entry share a word.
   smcs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_NONZEROS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (dt_wr_en),
      .wr_addr (dt_wr_addr),
      .wr_data (dt_wr_data),
      .rd_en   (dt_rd_en),
      .rd_addr (dt_rd_addr),
      .rd_data (dt_rd_data)
   );

   assign {dt_rd_value, dt_rd_col} = dt_rd_data;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load_blocked = (rows_eff == '0) || (cols_eff == '0) || loaded_ff ||
                         (load_row_ff >= rows_eff);
   assign col_inc      = CFG_WIDTH'(load_col_ff) + CFG_WIDTH'(1);
   assign row_inc      = load_row_ff + CFG_WIDTH'(1);
   assign col_last     = (col_inc >= cols_eff);
   assign ptr_next     = ptr_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      count_in    = count_ff;
      loaded_in   = loaded_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      qcol_in     = qcol_ff;
      row_next_in = row_next_ff;
      status_in   = status_ff;
      pop         = 1'b0;
      res_load    = 1'b0;
      res_value   = '0;
      res_status  = STATUS_OK;
      ld_status   = STATUS_OK;
      rs_wr_en    = 1'b0;
      rs_wr_addr  = RS_AW'(load_row_ff);
      rs_wr_data  = count_ff;
      rs_rd_en    = 1'b0;
      rs_rd_addr  = RS_AW'(fe.item.row);
      dt_wr_en    = 1'b0;
      dt_wr_addr  = ADDR_W'(count_ff);
      dt_wr_data  = {fe.item.value, load_col_ff};
      dt_rd_en    = 1'b0;
      dt_rd_addr  = ADDR_W'(ptr_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (fe.valid && out_free) begin
               pop = 1'b1;
               unique case (fe.item.op)
                  OP_LOAD: begin
                     if (load_blocked) begin
                        res_load   = 1'b1;
                        res_status = STATUS_OVERFLOW;
                     end else begin
                        // The first element of a row records where that row starts.
                        rs_wr_en = (load_col_ff == '0);
                        if (fe.item.value != '0) begin
                           if (count_ff < CNT_W'(MAX_NONZEROS)) begin
                              dt_wr_en = 1'b1;
                              count_in = count_ff + CNT_W'(1);
                           end else begin
                              ld_status = STATUS_OVERFLOW;
                           end
                        end
                        if (col_last) begin
                           load_col_in = '0;
                           load_row_in = row_inc;
                        end else begin
                           load_col_in = COL_W'(col_inc);
                        end
                        if (col_last && row_inc >= rows_eff) begin
                           loaded_in = 1'b1;
                           status_in = ld_status;
                           state_in  = ST_FINISH;
                        end else begin
                           res_load   = 1'b1;
                           res_status = ld_status;
                        end
                     end
                  end
                  OP_QUERY: begin
                     if (!loaded_ff) begin
                        res_load   = 1'b1;
                        res_status = STATUS_NOT_LOADED;
                     end else begin
                        rs_rd_en    = 1'b1;
                        qcol_in     = fe.item.col;
                        row_next_in = RS_AW'({1'b0, fe.item.row} + CFG_WIDTH'(1));
                        state_in    = ST_ROW_LO;
                     end
                  end
                  default: begin
                     res_load   = 1'b1;
                     res_status = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            // Closing pointer one past the last row.
            rs_wr_en   = 1'b1;
            rs_wr_addr = RS_AW'(rows_eff);
            res_load   = 1'b1;
            res_status = status_ff;
            state_in   = ST_IDLE;
         end
         ST_ROW_LO: begin
            ptr_in     = rs_rd_data;
            rs_rd_en   = 1'b1;
            rs_rd_addr = row_next_ff;
            state_in   = ST_ROW_HI;
         end
         ST_ROW_HI: begin
            end_in = rs_rd_data;
            if (ptr_ff < rs_rd_data) begin
               dt_rd_en = 1'b1;
               state_in = ST_SCAN;
            end else begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // One stored entry of the row is checked each cycle, the next read already issued.
            if (dt_rd_col == COL_W'(qcol_ff)) begin
               res_load  = 1'b1;
               res_value = dt_rd_value;
               state_in  = ST_IDLE;
            end else if (ptr_next < end_ff) begin
               ptr_in     = ptr_next;
               dt_rd_en   = 1'b1;
               dt_rd_addr = ADDR_W'(ptr_next);
            end else begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         load_row_in = '0;
         load_col_in = '0;
         count_in    = '0;
         loaded_in   = 1'b0;
      end

      rsp_valid_in  = res_load || (rsp_valid_ff && rsp_stall);
      rsp_value_in  = res_load ? res_value : rsp_value_ff;
      rsp_status_in = res_load ? res_status : rsp_status_ff;
      rsp_count_in  = res_load ? NZ_COUNT_WIDTH'(count_in) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         count_ff     <= '0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         count_ff     <= count_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      qcol_ff       <= qcol_in;
      row_next_ff   <= row_next_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   `SMCS_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_NONZEROS), "stored count beyond capacity")
   `SMCS_ASSERT_IMPLIES(a_no_overwrite, res_load && rsp_valid_ff, !rsp_stall, "pending result overwritten")
   `SMCS_ASSERT_IMPLIES(a_scan_bound, state_ff == ST_SCAN, ptr_ff < end_ff, "scan pointer past row end")
   `SMCS_ASSERT_IMPLIES(a_loaded_col, loaded_ff, load_col_ff == '0, "column not at zero after load")
   `SMCS_ASSERT_NEXT(a_restart, restart, count_ff == '0 && !loaded_ff && load_row_ff == '0, "restart failed")

endmodule

@@ rtl/sparse_matrix_csr_store_core.sv @@
// A load result is registered on acceptance; the last element of the matrix goes through ST_FINISH.
// Errors are registered on acceptance; a query goes through ST_ROW_LO and ST_ROW_HI, since the row
// start memory is read twice, then ST_SCAN checks a non-empty row up to a match, inclusive.
// Throughput: one load per cycle while the output is not stalled; queries one at a time. A 2-beat
// input queue absorbs stalls. Reset (synchronous, active high) clears control, dimensions and load
// progress; the entry and row start memories are not cleared and no clearing pass runs.
module sparse_matrix_csr_store_core
   import smcs_pkg::*;
#(
   parameter int MAX_ROWS     = DEF_MAX_ROWS,
   parameter int MAX_COLS     = DEF_MAX_COLS,
   parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CFG_WIDTH-1:0]          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_element_value,
   input  logic [POS_WIDTH-1:0]          req_query_row,
   input  logic [POS_WIDTH-1:0]          req_query_col,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_value,
   output logic [1:0]                    rsp_status,
   output logic [NZ_COUNT_WIDTH-1:0]     rsp_nonzero_count
);

   logic [CFG_WIDTH-1:0] rows_eff_ff, rows_eff_in;
   logic [CFG_WIDTH-1:0] cols_eff_ff, cols_eff_in;
   logic [CFG_WIDTH-1:0] rows_clamped, cols_clamped;
   fe_item_type          fe;
   logic                 pop;
   status_type           back_status;

   // Dimensions are kept already limited to the store's capacity.
   assign rows_clamped = (csr_write_data > MAX_ROWS) ? CFG_WIDTH'(MAX_ROWS) : csr_write_data;
   assign cols_clamped = (csr_write_data > MAX_COLS) ? CFG_WIDTH'(MAX_COLS) : csr_write_data;

   always_comb begin
      rows_eff_in = rows_eff_ff;
      cols_eff_in = cols_eff_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_NUM_ROWS: rows_eff_in = rows_clamped;
            CSR_NUM_COLS: cols_eff_in = cols_clamped;
            default:      rows_eff_in = rows_eff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_eff_ff <= '0;
         cols_eff_ff <= '0;
      end else begin
         rows_eff_ff <= rows_eff_in;
         cols_eff_ff <= cols_eff_in;
      end
   end

   smcs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .rows_eff          (rows_eff_ff),
      .cols_eff          (cols_eff_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_element_value (req_element_value),
      .req_query_row     (req_query_row),
      .req_query_col     (req_query_col),
      .fe                (fe),
      .pop               (pop)
   );

   smcs_back #(
      .MAX_ROWS     (MAX_ROWS),
      .MAX_COLS     (MAX_COLS),
      .MAX_NONZEROS (MAX_NONZEROS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write_en),
      .rows_eff   (rows_eff_ff),
      .cols_eff   (cols_eff_ff),
      .fe         (fe),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_result_value),
      .rsp_status (back_status),
      .rsp_count  (rsp_nonzero_count)
   );

   assign rsp_status = back_status;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import smcs_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_ITEMS = 900;
   localparam int TAIL_CYCLES  = 80;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      status_type                    status;
      logic [NZ_COUNT_WIDTH-1:0]     count;
   } lookup_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_write_en   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index      = CSR_NUM_ROWS;
   logic [CFG_WIDTH-1:0]          csr_write_data = '0;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic                          req_kind          = KIND_LOAD;
   logic signed [VALUE_WIDTH-1:0] req_element_value = '0;
   logic [POS_WIDTH-1:0]          req_query_row     = '0;
   logic [POS_WIDTH-1:0]          req_query_col     = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_result_value;
   logic [1:0]                    rsp_status;
   logic [NZ_COUNT_WIDTH-1:0]     rsp_nonzero_count;

   sparse_matrix_csr_store_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_element_value (req_element_value),
      .req_query_row     (req_query_row),
      .req_query_col     (req_query_col),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_nonzero_count (rsp_nonzero_count)
   );

   initial forever #4 clock = ~clock;

   // Shadow copy of the compressed store.
   logic signed [VALUE_WIDTH-1:0] entry_value [0:DEF_MAX_NONZEROS-1];
   logic [POS_WIDTH-1:0]          entry_col   [0:DEF_MAX_NONZEROS-1];
   logic [NZ_COUNT_WIDTH-1:0]     row_first   [0:DEF_MAX_ROWS];
   logic [CFG_WIDTH-1:0]          cfg_rows    = '0;
   logic [CFG_WIDTH-1:0]          cfg_cols    = '0;
   logic [CFG_WIDTH-1:0]          fill_row    = '0;
   logic [POS_WIDTH-1:0]          fill_col    = '0;
   logic [NZ_COUNT_WIDTH-1:0]     nz_count    = '0;
   bit                            matrix_done = 1'b0;

   lookup_answer_type answers_due[$];
   int  mismatches   = 0;
   int  items_sent   = 0;
   int  hold_cycles  = 0;
   bit  send_no_idle = 1'b0;
   bit  take_no_idle = 1'b0;

   function int unsigned eff_rows();
      return (cfg_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cfg_rows;
   endfunction

   function int unsigned eff_cols();
      return (cfg_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cfg_cols;
   endfunction

   task apply_csr_write(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [CFG_WIDTH-1:0] data);
      if (index == CSR_NUM_ROWS) begin
         cfg_rows = data;
      end else begin
         cfg_cols = data;
      end
      fill_row    = '0;
      fill_col    = '0;
      nz_count    = '0;
      matrix_done = 1'b0;
   endtask

   task predict_answer(input logic kind, input logic signed [VALUE_WIDTH-1:0] value,
                       input logic [POS_WIDTH-1:0] row, input logic [POS_WIDTH-1:0] col);
      lookup_answer_type ans;
      int unsigned    rows;
      int unsigned    cols;
      int             r;
      int             start_idx;
      int             end_idx;
      int             i;
      bit             hit;
      rows      = eff_rows();
      cols      = eff_cols();
      ans.value = '0;
      ans.status = STATUS_OK;
      if (kind == KIND_LOAD) begin
         if (rows == 0 || cols == 0 || matrix_done || fill_row >= rows) begin
            ans.status = STATUS_OVERFLOW;
         end else begin
            if (fill_col == 0) row_first[fill_row] = nz_count;
            if (value != 0) begin
               if (nz_count < DEF_MAX_NONZEROS) begin
                  entry_value[nz_count] = value;
                  entry_col[nz_count]   = fill_col;
                  nz_count++;
               end else begin
                  ans.status = STATUS_OVERFLOW;
               end
            end
            if (fill_col + 1 >= cols) begin
               fill_col = '0;
               fill_row++;
               if (fill_row >= rows) begin
                  row_first[rows] = nz_count;
                  matrix_done     = 1'b1;
               end
            end else begin
               fill_col++;
            end
         end
      end else begin
         if (row >= rows || col >= cols) begin
            ans.status = STATUS_RANGE;
         end else if (!matrix_done) begin
            ans.status = STATUS_NOT_LOADED;
         end else begin
            r         = row;
            start_idx = row_first[r];
            end_idx   = row_first[r + 1];
            if (end_idx > DEF_MAX_NONZEROS) end_idx = DEF_MAX_NONZEROS;
            hit = 1'b0;
            for (i = start_idx; i < end_idx && !hit; i++) begin
               if (entry_col[i] == col) begin
                  ans.value = entry_value[i];
                  hit       = 1'b1;
               end
            end
         end
      end
      ans.count = nz_count;
      answers_due.push_back(ans);
   endtask

   function logic signed [VALUE_WIDTH-1:0] rand_element();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return '0;
         4:          return 32'sh7FFFFFFF;
         5:          return 32'sh80000000;
         6:          return -32'sd1;
         default:    return $urandom;
      endcase
   endfunction

   // The previous beat may leave valid high, so a gap of zero keeps it up.
   task send_beat(input logic kind, input logic signed [VALUE_WIDTH-1:0] value,
                  input logic [POS_WIDTH-1:0] row, input logic [POS_WIDTH-1:0] col);
      int gap;
      gap = send_no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_element_value <= value;
      req_query_row     <= row;
      req_query_col     <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_answer(kind, value, row, col);
      items_sent++;
   endtask

   task send_query(input int row, input int col);
      send_beat(KIND_QUERY, rand_element(), POS_WIDTH'(row), POS_WIDTH'(col));
   endtask

   task send_load(input logic signed [VALUE_WIDTH-1:0] value);
      send_beat(KIND_LOAD, value, POS_WIDTH'($urandom_range(0, 63)),
                POS_WIDTH'($urandom_range(0, 63)));
   endtask

   task wait_all_answered();
      @(negedge clock);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_INDEX_WIDTH-1:0] index, input int data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= CFG_WIDTH'(data);
      apply_csr_write(index, CFG_WIDTH'(data));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task note_mismatch(input string what, input longint expected_v, input longint actual_v);
      if (mismatches < 10) begin
         $display("mismatch on %s: expected %0d, got %0d", what, expected_v, actual_v);
      end
      mismatches++;
   endtask

   // Receiver: a random stall ahead of every beat unless take_no_idle is set, or a long hold when one is requested.
   initial begin
      int n;
      wait (reset == 1'b0);
      forever begin
         if (hold_cycles > 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
         end else begin
            n = take_no_idle ? 0 : $urandom_range(0, 14);
         end
         if (n > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (n - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      lookup_answer_type ans;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            note_mismatch("result with nothing pending, status", -1, rsp_status);
         end else begin
            ans = answers_due.pop_front();
            if (rsp_result_value !== ans.value)
               note_mismatch("result_value", ans.value, rsp_result_value);
            if (rsp_status !== ans.status)
               note_mismatch("status", ans.status, rsp_status);
            if (rsp_nonzero_count !== ans.count)
               note_mismatch("nonzero_count", ans.count, rsp_nonzero_count);
         end
      end
   end

   // Watchdog: too long without a beat on either channel ends the run.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      wait (reset == 1'b0);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // With a zero dimension, loads overflow and queries are out of range.
   task test_empty_matrix();
      send_load(32'sd5);
      send_query(0, 0);
      wait_all_answered();
      write_reg(CSR_NUM_ROWS, 127);
      write_reg(CSR_NUM_COLS, 0);
      send_query(63, 0);
      send_load(-32'sd1);
      wait_all_answered();
   endtask

   task test_small_matrix();
      write_reg(CSR_NUM_ROWS, 2);
      write_reg(CSR_NUM_COLS, 3);
      // The range check wins over the not-loaded check.
      send_query(5, 0);
      send_query(0, 0);
      send_load(32'sh7FFFFFFF);
      send_load(32'sd0);
      send_load(32'sh80000000);
      send_query(1, 1);
      send_load(32'sd0);
      send_load(32'sd0);
      send_load(-32'sd1);
      send_query(0, 0);
      send_query(0, 1);
      send_query(0, 2);
      send_query(1, 2);
      send_query(1, 0);
      send_query(2, 0);
      send_query(0, 3);
      send_query(63, 63);
      // Past the last element nothing changes.
      send_load(32'sd9);
      wait_all_answered();
   endtask

   // A register write in the middle of a load starts loading over.
   task test_restart_on_write();
      write_reg(CSR_NUM_ROWS, 2);
      write_reg(CSR_NUM_COLS, 2);
      send_load(32'sd5);
      send_load(32'sd0);
      wait_all_answered();
      write_reg(CSR_NUM_COLS, 2);
      send_query(0, 0);
      wait_all_answered();
   endtask

   // The receiver holds off while beats keep coming, so the input side has to stall.
   task test_backpressure();
      int k;
      write_reg(CSR_NUM_ROWS, 3);
      write_reg(CSR_NUM_COLS, 4);
      hold_cycles  = HOLD_CYCLES;
      send_no_idle = 1'b1;
      for (k = 0; k < 12; k++) send_load(rand_element());
      for (k = 0; k < 6; k++) send_query($urandom_range(0, 3), $urandom_range(0, 4));
      wait_all_answered();
      send_no_idle = 1'b0;
   endtask

   task test_random_matrices();
      int stop_at;
      int rows_cfg;
      int cols_cfg;
      int er;
      int ec;
      int cut;
      int n_queries;
      int k;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               rows_cfg = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
               cols_cfg = $urandom_range(1, 2);
            end
            1: begin
               rows_cfg = $urandom_range(1, 2);
               cols_cfg = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
            end
            2: begin
               rows_cfg = $urandom_range(0, 1) ? 0 : $urandom_range(0, 127);
               cols_cfg = (rows_cfg == 0) ? $urandom_range(0, 127) : 0;
            end
            default: begin
               rows_cfg = $urandom_range(1, 8);
               cols_cfg = $urandom_range(1, 8);
            end
         endcase
         send_no_idle = ($urandom_range(0, 3) == 0);
         take_no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) write_reg(CSR_NUM_ROWS, $urandom_range(0, 127));
         if ($urandom_range(0, 1)) begin
            write_reg(CSR_NUM_ROWS, rows_cfg);
            write_reg(CSR_NUM_COLS, cols_cfg);
         end else begin
            write_reg(CSR_NUM_COLS, cols_cfg);
            write_reg(CSR_NUM_ROWS, rows_cfg);
         end
         er = eff_rows();
         ec = eff_cols();
         // Now and then the load is cut short, leaving the matrix incomplete.
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, er * ec) : er * ec;
         for (k = 0; k < cut; k++) begin
            if ($urandom_range(0, 19) == 0) send_query($urandom_range(0, 63), $urandom_range(0, 63));
            send_load(rand_element());
         end
         n_queries = $urandom_range(3, 14);
         for (k = 0; k < n_queries; k++) begin
            if (er == 0 || ec == 0 || $urandom_range(0, 4) == 0)
               send_query($urandom_range(0, 63), $urandom_range(0, 63));
            else
               send_query($urandom_range(0, er - 1), $urandom_range(0, ec - 1));
         end
         if ($urandom_range(0, 5) == 0) send_load(rand_element());
         wait_all_answered();
      end
      send_no_idle = 1'b0;
      take_no_idle = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_matrix();
      test_small_matrix();
      test_restart_on_write();
      test_backpressure();
      test_random_matrices();
      wait_all_answered();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/smcs_pkg.sv
rtl/smcs_ram.sv
rtl/smcs_front.sv
rtl/smcs_back.sv
rtl/sparse_matrix_csr_store_core.sv
verif/testbench.sv
